// ===== src/sbr_pkg.sv =====
// Shared constants and types for the scrollback ring buffer.
package sbr_pkg;

    localparam int RING_LINES = 1024;
    localparam int SLOT_W     = $clog2(RING_LINES);
    localparam int FROM_MAX   = 24;
    localparam int TEXT_MAX   = 510;

    localparam int FROM_W     = 5;
    localparam int TEXT_W     = 9;
    localparam int CNT_W      = 11;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SCROLL = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [3:0]        line_type;
        logic [FROM_W-1:0] sender_len;
        logic [TEXT_W-1:0] msg_len;
        logic [7:0]        prefix;
        logic [31:0]       stamp;
    } line_rec_t;

    localparam int REC_W = $bits(line_rec_t);

endpackage

// ===== src/sbr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/scrollback_ring_buffer.sv =====
// Scrollback ring buffer: line descriptor ring with head, tail and scroll counters.
// Result strobe (done) is registered and rises in the cycle after a command is accepted.
// Throughput: one command per cycle; busy never rises, since every command
// touches at most one RAM entry (write for push, registered read for read).
// Reset clears head, tail, scroll and pad width; the line RAM is not cleared,
// and only lines between tail and head can be read.
// The receiver cannot stall: done is high for one cycle only; status and entry fields hold until the next command.
module scrollback_ring_buffer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [31:0]                 index,
    input  logic [3:0]                  line_type,
    input  logic [15:0]                 sender_len,
    input  logic [15:0]                 msg_len,
    input  logic [7:0]                  prefix,
    input  logic [31:0]                 timestamp,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [3:0]                  entry_type,
    output logic [sbr_pkg::FROM_W-1:0]  entry_sender_len,
    output logic [sbr_pkg::TEXT_W-1:0]  entry_msg_len,
    output logic [7:0]                  entry_prefix,
    output logic [31:0]                 entry_time,
    output logic [sbr_pkg::CNT_W-1:0]   line_count,
    output logic [31:0]                 head_count,
    output logic [31:0]                 tail_count,
    output logic [31:0]                 scroll_out,
    output logic [sbr_pkg::FROM_W-1:0]  pad_width
);

    import sbr_pkg::*;

    logic [31:0]       head_reg, head_next;
    logic [31:0]       tail_reg, tail_next;
    logic [31:0]       scroll_reg, scroll_next;
    logic [FROM_W-1:0] pad_reg, pad_next;
    logic [1:0]        status_reg, status_next;
    logic              done_reg;
    logic              rd_ok_reg, rd_ok_next;

    logic              accept;
    logic [31:0]       size;
    logic              empty, full;
    logic [31:0]       scroll_snap;
    logic [16:0]       flen_raw;
    logic [FROM_W-1:0] flen;
    logic [TEXT_W-1:0] tlen;
    logic              wr_en, rd_en;
    line_rec_t         wr_rec, rd_rec;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    assign size  = head_reg - tail_reg;
    assign empty = (size == 32'd0);
    assign full  = (size == 32'(RING_LINES));

    assign scroll_snap = (empty || (scroll_reg == head_reg - 32'd1)) ? head_reg : scroll_reg;

    // sender length counts the prefix character
    assign flen_raw = {1'b0, sender_len} + {16'd0, (prefix != 8'd0)};
    assign flen = (flen_raw > 17'(FROM_MAX)) ? FROM_W'(FROM_MAX) : flen_raw[FROM_W-1:0];
    assign tlen = (msg_len > 16'(TEXT_MAX)) ? TEXT_W'(TEXT_MAX) : msg_len[TEXT_W-1:0];

    assign wr_rec.line_type  = line_type;
    assign wr_rec.sender_len = flen;
    assign wr_rec.msg_len    = tlen;
    assign wr_rec.prefix     = prefix;
    assign wr_rec.stamp      = timestamp;

    assign wr_en = accept && (opcode == OP_PUSH);
    assign rd_en = accept && (opcode == OP_READ);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        scroll_next = scroll_reg;
        pad_next    = pad_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        if (accept)
        begin
            case (opcode)
                OP_PUSH:
                begin
                    scroll_next = scroll_snap;
                    if (full)
                    begin
                        // oldest line drops out; scroll rides along if it sat on it
                        if (scroll_snap == tail_reg)
                        begin
                            scroll_next = scroll_snap + 32'd1;
                        end
                        tail_next = tail_reg + 32'd1;
                    end
                    head_next = head_reg + 32'd1;
                    if (flen > pad_reg)
                    begin
                        pad_next = flen;
                    end
                end
                OP_READ:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if ((index - tail_reg) >= size)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                OP_SCROLL:
                begin
                    scroll_next = index;
                end
                OP_QUERY:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            scroll_reg <= '0;
            pad_reg    <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            scroll_reg <= scroll_next;
            pad_reg    <= pad_next;
            done_reg   <= accept;
            if (accept)
            begin
                status_reg <= status_next;
                rd_ok_reg  <= rd_ok_next;
            end
        end
    end

    // push writes at the accept edge, so a read on the next cycle already sees it
    sbr_ram #(
        .WIDTH (REC_W),
        .DEPTH (RING_LINES)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (head_reg[SLOT_W-1:0]),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (index[SLOT_W-1:0]),
        .rd_data (rd_rec)
    );

    assign done             = done_reg;
    assign status           = status_reg;
    assign entry_type       = rd_ok_reg ? rd_rec.line_type : 4'd0;
    assign entry_sender_len = rd_ok_reg ? rd_rec.sender_len : '0;
    assign entry_msg_len    = rd_ok_reg ? rd_rec.msg_len : '0;
    assign entry_prefix     = rd_ok_reg ? rd_rec.prefix : 8'd0;
    assign entry_time       = rd_ok_reg ? rd_rec.stamp : 32'd0;
    assign line_count       = size[CNT_W-1:0];
    assign head_count       = head_reg;
    assign tail_count       = tail_reg;
    assign scroll_out       = scroll_reg;
    assign pad_width        = pad_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("done without a prior accepted command");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg - tail_reg) <= 32'(RING_LINES))
        else $error("ring holds more lines than slots");

    a_read_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rd_ok_reg |-> (status_reg == ST_OK))
        else $error("read data flagged with error status");

    a_push_advances_head: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_PUSH)) |=> (head_reg == $past(head_reg) + 32'd1))
        else $error("push did not advance head");

    a_pad_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pad_reg >= $past(pad_reg)))
        else $error("pad width decreased");

endmodule
